FILE: rtl/core/kbc_pkg.sv
package kbc_pkg;

	localparam int unsigned KeyWords = 4;

	// Configuration register map
	typedef enum logic [1:0] {
		REG_KEY_WORD0 = 2'd0,
		REG_KEY_WORD1 = 2'd1,
		REG_KEY_WORD2 = 2'd2,
		REG_KEY_WORD3 = 2'd3
	} kbc_reg_t;

	localparam logic [31:0] KEY_RESET0 = 32'h4B32_4452;
	localparam logic [31:0] KEY_RESET1 = 32'hEFBE_ADDE;
	localparam logic [31:0] KEY_RESET2 = 32'hBEBA_FECA;
	localparam logic [31:0] KEY_RESET3 = 32'h2620_0020;

	localparam logic [7:0] MASK_STEP  = 8'd37;
	localparam logic [2:0] PHASE_LAST = 3'd6;
	localparam logic [2:0] PHASE_INIT = 3'd1;
	localparam logic [2:0] PHASE_TOP  = 3'd7;

	localparam logic       ACT_ENCRYPT = 1'b0;
	localparam logic       ACT_DECRYPT = 1'b1;

	// Everything the datapath needs for one byte, captured at acceptance
	typedef struct packed {
		logic       action;
		logic [7:0] data_byte;
		logic       last_of_message;
		logic [7:0] key_byte;
		logic [7:0] mask;
		logic [2:0] phase;
	} kbc_work_t;

	typedef struct packed {
		logic [7:0] result_byte;
		logic       result_last;
	} kbc_res_t;

	localparam logic [7:0] FWD_BOX [256] = '{
		8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
		8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
		8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
		8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
		8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
		8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
		8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
		8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
		8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
		8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
		8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
		8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
		8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
		8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
		8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
		8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
	};

	localparam logic [7:0] INV_BOX [256] = '{
		8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
		8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
		8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
		8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
		8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
		8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
		8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
		8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
		8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
		8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
		8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
		8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
		8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
		8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
		8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
	};

endpackage

FILE: rtl/core/kbc_if.sv
interface kbc_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] data_byte;
	logic       last_of_message;

	modport source (output valid, action, data_byte, last_of_message, input ready);
	modport sink   (input valid, action, data_byte, last_of_message, output ready);
endinterface

interface kbc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] result_byte;
	logic       result_last;

	modport source (output valid, result_byte, result_last, input ready);
	modport sink   (input valid, result_byte, result_last, output ready);
endinterface

interface kbc_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/kbc_xform.sv
module kbc_xform
	import kbc_pkg::*;
(
	input  kbc_work_t work,
	output kbc_res_t  res
);

	logic [2:0]  amount;
	logic [7:0]  enc_sub;
	logic [15:0] enc_dbl;
	logic [7:0]  dec_unmask;
	logic [15:0] dec_dbl;
	logic [7:0]  dec_rot;

	// phase 7 never occurs; clamp keeps the rotate well defined
	assign amount = (work.phase == PHASE_TOP) ? PHASE_TOP : work.phase + 3'd1;

	// encrypt: key xor, S-box, rotate left, mask
	assign enc_sub = FWD_BOX[work.data_byte ^ work.key_byte];
	assign enc_dbl = {enc_sub, enc_sub} << amount;

	// decrypt: unmask, rotate right, inverse S-box, key xor
	assign dec_unmask = work.data_byte ^ work.mask;
	assign dec_dbl    = {dec_unmask, dec_unmask} >> amount;
	assign dec_rot    = dec_dbl[7:0];

	always_comb begin
		res.result_last = work.last_of_message;
		unique case (work.action)
			ACT_ENCRYPT: res.result_byte = enc_dbl[15:8] ^ work.mask;
			ACT_DECRYPT: res.result_byte = INV_BOX[dec_rot] ^ work.key_byte;
			default:     res.result_byte = '0;
		endcase
	end

endmodule

FILE: rtl/core/kbc_skid.sv
module kbc_skid
	import kbc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  kbc_res_t   in_res,
	kbc_out_if.source  dout
);

	logic     out_vld_q;
	logic     skid_vld_q;
	kbc_res_t out_q;
	kbc_res_t skid_q;
	logic     take;
	logic     fire;

	assign in_ready = !skid_vld_q;
	assign take     = in_valid && in_ready;
	assign fire     = out_vld_q && dout.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (fire) begin
				if (skid_vld_q) begin
					skid_vld_q <= 1'b0;
				end else begin
					out_vld_q <= take;
				end
			end else if (take) begin
				if (out_vld_q) begin
					skid_vld_q <= 1'b1;
				end else begin
					out_vld_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			if (skid_vld_q) begin
				out_q <= skid_q;
			end else if (take) begin
				out_q <= in_res;
			end
		end else if (take) begin
			if (out_vld_q) begin
				skid_q <= in_res;
			end else begin
				out_q <= in_res;
			end
		end
	end

	assign dout.valid       = out_vld_q;
	assign dout.result_byte = out_q.result_byte;
	assign dout.result_last = out_q.result_last;

endmodule

FILE: rtl/core/keyed_sbox_rotate_byte_cipher.sv
// Keyed S-box / rotate byte cipher: one byte out for every byte in.
// din  : request carries action (0 encrypt, 1 decrypt), data_byte and
//        last_of_message; taken when valid and ready are both high.
// dout : request carries result_byte and result_last (copy of the flag).
// cfg  : key register writes, index 0..3 selects key word 0..3 (byte 0 of
//        each word in bits 7:0). Always ready; write only when idle.
// Path: a byte taken on din goes into the input register, then through
//        the cipher logic into the result register (or the skid entry
//        while dout is held off), and is offered on dout from there.
// Throughput: one byte per cycle unless dout holds off, set by the S-box
//        lookup, rotate and XOR logic between the two registers.
// Position state (byte index, rotate phase, running mask) steps on every
// accepted byte and restarts after a byte flagged last.
// Reset: key returns to the built-in default, position restarts at zero,
//        all pipeline and output valids clear.
// Stall: input register, result register and a one-entry skid hold three
//        bytes; din keeps taking bytes until the skid entry and the input
//        register are both occupied, so nothing is lost or repeated while
//        dout is held off.
module keyed_sbox_rotate_byte_cipher
	import kbc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	kbc_in_if.sink    din,
	kbc_out_if.source dout,
	kbc_cfg_if.sink   cfg
);

	// key store and position state
	logic [31:0] key_q [KeyWords];
	logic [7:0]  pos_q;
	logic [2:0]  phase_q;
	logic [7:0]  mask_q;

	// input register
	logic      vld_s1;
	kbc_work_t work_s1;

	logic        accept;
	logic        s1_ready;
	logic        skid_ready;
	logic [31:0] key_word;
	logic [31:0] key_shift;
	kbc_res_t    res;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q[0] <= KEY_RESET0;
			key_q[1] <= KEY_RESET1;
			key_q[2] <= KEY_RESET2;
			key_q[3] <= KEY_RESET3;
		end else if (cfg.valid) begin
			unique case (kbc_reg_t'(cfg.index))
				REG_KEY_WORD0: key_q[0] <= cfg.data;
				REG_KEY_WORD1: key_q[1] <= cfg.data;
				REG_KEY_WORD2: key_q[2] <= cfg.data;
				REG_KEY_WORD3: key_q[3] <= cfg.data;
				default: ;
			endcase
		end
	end

	// key byte i mod 16: word by bits 3:2, byte lane by bits 1:0
	assign key_word  = key_q[pos_q[3:2]];
	assign key_shift = key_word >> {pos_q[1:0], 3'b000};

	assign s1_ready  = !vld_s1 || skid_ready;
	assign din.ready = s1_ready;
	assign accept    = din.valid && s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			phase_q <= PHASE_INIT;
			mask_q  <= '0;
			vld_s1  <= 1'b0;
		end else begin
			if (accept) begin
				vld_s1 <= 1'b1;
				if (din.last_of_message) begin
					pos_q   <= '0;
					phase_q <= PHASE_INIT;
					mask_q  <= '0;
				end else begin
					pos_q   <= pos_q + 8'd1;
					phase_q <= (phase_q >= PHASE_LAST) ? 3'd0 : phase_q + 3'd1;
					mask_q  <= mask_q + MASK_STEP;
				end
			end else if (skid_ready) begin
				vld_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			work_s1.action          <= din.action;
			work_s1.data_byte       <= din.data_byte;
			work_s1.last_of_message <= din.last_of_message;
			work_s1.key_byte        <= key_shift[7:0];
			work_s1.mask            <= mask_q;
			work_s1.phase           <= phase_q;
		end
	end

	kbc_xform u_xform (
		.work (work_s1),
		.res  (res)
	);

	kbc_skid u_skid (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s1),
		.in_ready (skid_ready),
		.in_res   (res),
		.dout     (dout)
	);

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps

// Byte cipher testbench.
// Requests go in on din with random gaps. Results are taken from dout with
// random stalls. Key words are loaded through cfg only while the block is
// idle. Every accepted din request is run through a local copy of the
// cipher. The prediction is queued and then matched against the next dout
// request, field by field.
module tb;
	import kbc_pkg::*;

	localparam int unsigned QUIET_LIMIT = 2000;	// cycles with no accepted request
	localparam int unsigned REPORT_MAX  = 10;
	localparam int unsigned SETTLE_CYCLES = 8;	// after the drain, to catch a stray extra result
	localparam logic [7:0]  MASK_INC    = 8'd37;
	localparam logic [2:0]  PHASE_WRAP  = 3'd6;
	localparam logic [2:0]  PHASE_START = 3'd1;
	localparam logic [127:0] KEY_DEFAULT =
		{32'h2620_0020, 32'hBEBA_FECA, 32'hEFBE_ADDE, 32'h4B32_4452};

	logic clk;
	logic arst_n;

	kbc_in_if  din_if();
	kbc_out_if dout_if();
	kbc_cfg_if cfg_if();

	keyed_sbox_rotate_byte_cipher dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_if),
		.dout   (dout_if),
		.cfg    (cfg_if)
	);

	// ---------------------------------------------------------------
	// Local cipher state: key words, byte position, rotate phase and
	// the running mask (position * 37, mod 256)
	// ---------------------------------------------------------------
	logic [7:0]  fwd_sbox [256];
	logic [7:0]  rev_sbox [256];
	logic [31:0] key_copy [4];
	logic [7:0]  byte_index;
	logic [2:0]  rot_phase;
	logic [7:0]  run_mask;

	kbc_res_t    pending_bytes [$];	// predicted results, oldest first
	int unsigned error_count;
	int unsigned quiet_cycles;
	int unsigned in_gap_max;		// upper bound of the gap before each din request
	int unsigned out_stall_max;		// upper bound of the stall before each dout request

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [7:0] rotate_left8(input logic [7:0] v, input int unsigned amt);
		logic [15:0] w;
		w = {v, v} << amt;
		return w[15:8];
	endfunction

	// Cipher one byte at the current position, then step the position.
	// After a byte flagged last, the position starts again at zero.
	function automatic kbc_res_t transform_byte(input logic act, input logic [7:0] in_byte,
			input logic last);
		logic [7:0]  kb;
		logic [7:0]  t;
		int unsigned amt;
		kbc_res_t    r;
		kb  = key_copy[byte_index[3:2]][{byte_index[1:0], 3'b000} +: 8];
		amt = int'(rot_phase) + 1;
		if (amt > 7)
			amt = 7;	// phase 7 cannot occur; clamp as the block does
		if (act == ACT_ENCRYPT)
			t = rotate_left8(fwd_sbox[in_byte ^ kb], amt) ^ run_mask;
		else
			t = rev_sbox[rotate_left8(in_byte ^ run_mask, 8 - amt)] ^ kb;
		r.result_byte = t;
		r.result_last = last;
		if (last) begin
			byte_index = '0;
			rot_phase  = PHASE_START;
			run_mask   = '0;
		end else begin
			byte_index = byte_index + 8'd1;
			rot_phase  = (rot_phase >= PHASE_WRAP) ? 3'd0 : rot_phase + 3'd1;
			run_mask   = run_mask + MASK_INC;
		end
		return r;
	endfunction

	function automatic int unsigned pick_pace();
		case ($urandom_range(2))
			0: return 0;
			1: return 3;
			default: return 19;
		endcase
	endfunction

	// Byte values lean towards the extremes now and then
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(9))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic note_error(input string msg);
		if (error_count < REPORT_MAX)
			$display("tb: mismatch: %s", msg);
		error_count++;
	endtask

	// ---------------------------------------------------------------
	// Request driver: optional gap, then hold valid until accepted.
	// Valid stays high on return, so back-to-back requests have no
	// bubble. The prediction is made at the edge of acceptance.
	// ---------------------------------------------------------------
	task automatic send_byte(input logic act, input logic [7:0] b, input logic last);
		int unsigned gap;
		gap = $urandom_range(in_gap_max, 0);
		if (gap != 0) begin
			din_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		din_if.valid           <= 1'b1;
		din_if.action          <= act;
		din_if.data_byte       <= b;
		din_if.last_of_message <= last;
		do @(posedge clk); while (!din_if.ready);
		pending_bytes.push_back(transform_byte(act, b, last));
	endtask

	task automatic send_message(input int unsigned len);
		for (int unsigned i = 0; i < len; i++)
			send_byte(1'($urandom_range(1)), pick_byte(), i == len - 1);
	endtask

	// Mostly short messages, now and then a longer one
	task automatic send_messages(input int unsigned total);
		int unsigned sent;
		int unsigned len;
		sent = 0;
		while (sent < total) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(60, 25) : $urandom_range(24, 1);
			send_message(len);
			sent += len;
		end
	endtask

	// Stop sending and wait for every predicted result to come out.
	// Every byte gives a result, so an empty queue means the block is idle.
	task automatic drain();
		din_if.valid <= 1'b0;
		while (pending_bytes.size() != 0)
			@(posedge clk);
	endtask

	// Load the selected key words, block idle first
	task automatic program_key(input logic [127:0] k, input logic [3:0] sel);
		drain();
		for (int i = 0; i < 4; i++) begin
			if (sel[i]) begin
				cfg_if.valid <= 1'b1;
				cfg_if.index <= kbc_reg_t'(i);
				cfg_if.data  <= k[32*i +: 32];
				do @(posedge clk); while (!cfg_if.ready);
				key_copy[kbc_reg_t'(i)] = k[32*i +: 32];
			end
		end
		cfg_if.valid <= 1'b0;
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Default key: byte extremes, both actions, an eight-byte message that
	// takes the rotate phase round its full cycle (past 6 and back to 0),
	// then two one-byte messages and a three-byte one with random pacing
	task automatic test_directed_extremes();
		in_gap_max    = 0;
		out_stall_max = 0;
		send_byte(ACT_ENCRYPT, 8'h00, 1'b0);
		send_byte(ACT_ENCRYPT, 8'hFF, 1'b0);
		send_byte(ACT_DECRYPT, 8'h00, 1'b0);
		send_byte(ACT_DECRYPT, 8'hFF, 1'b0);
		send_byte(ACT_ENCRYPT, 8'h80, 1'b0);
		send_byte(ACT_DECRYPT, 8'h01, 1'b0);
		send_byte(ACT_ENCRYPT, 8'h7F, 1'b0);
		send_byte(ACT_DECRYPT, 8'hFE, 1'b1);
		send_byte(ACT_ENCRYPT, 8'hFF, 1'b1);
		send_byte(ACT_DECRYPT, 8'h00, 1'b1);
		in_gap_max    = 19;
		out_stall_max = 19;
		send_byte(ACT_DECRYPT, 8'h5A, 1'b0);
		send_byte(ACT_ENCRYPT, 8'hA5, 1'b0);
		send_byte(ACT_DECRYPT, 8'hFF, 1'b1);
	endtask

	// New key words loaded part way through a message: they apply from the
	// next byte, and the position carries on
	task automatic test_key_midmessage();
		in_gap_max    = pick_pace();
		out_stall_max = pick_pace();
		send_byte(ACT_ENCRYPT, 8'h11, 1'b0);
		send_byte(ACT_DECRYPT, 8'h22, 1'b0);
		send_byte(ACT_ENCRYPT, 8'h33, 1'b0);
		program_key({32'h0, 32'h0, 32'h0123_4567, 32'hFFFF_FFFF}, 4'b0011);
		send_byte(ACT_ENCRYPT, 8'h44, 1'b0);
		send_byte(ACT_DECRYPT, 8'h55, 1'b0);
		send_byte(ACT_ENCRYPT, 8'h66, 1'b1);
	endtask

	// Random messages under a range of keys: all zeros, all ones, mixed,
	// random, and the default again
	task automatic test_key_sweep();
		logic [127:0] k;
		for (int s = 0; s < 6; s++) begin
			case (s)
				0: k = '0;
				1: k = '1;
				2: k = {32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0};
				5: k = KEY_DEFAULT;
				default: k = {$urandom, $urandom, $urandom, $urandom};
			endcase
			program_key(k, 4'b1111);
			in_gap_max    = pick_pace();
			out_stall_max = pick_pace();
			send_messages(60);
		end
	endtask

	// One message past 256 bytes, so the byte position wraps
	task automatic test_long_message();
		program_key({$urandom, $urandom, $urandom, $urandom}, 4'b1111);
		in_gap_max    = 3;
		out_stall_max = 3;
		send_message(280);
	endtask

	// ---------------------------------------------------------------
	// Result checker: each dout request against the oldest prediction
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		kbc_res_t want;
		if (dout_if.valid && dout_if.ready) begin
			if (pending_bytes.size() == 0) begin
				note_error($sformatf("unexpected result byte %02h last %0b",
					dout_if.result_byte, dout_if.result_last));
			end else begin
				want = pending_bytes.pop_front();
				if (dout_if.result_byte !== want.result_byte)
					note_error($sformatf("result_byte expected %02h got %02h",
						want.result_byte, dout_if.result_byte));
				if (dout_if.result_last !== want.result_last)
					note_error($sformatf("result_last expected %0b got %0b",
						want.result_last, dout_if.result_last));
			end
		end
	end

	// Result sink: random stall before each request, then ready until taken
	initial begin
		int unsigned stall;
		dout_if.ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			stall = $urandom_range(out_stall_max, 0);
			if (stall != 0) begin
				dout_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			dout_if.ready <= 1'b1;
			do @(posedge clk); while (!(dout_if.valid && dout_if.ready));
		end
	end

	// Watchdog: too long with no request accepted on any channel
	always @(posedge clk) begin
		if ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready) ||
				(cfg_if.valid && cfg_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		logic [7:0] p;
		logic [7:0] q;
		logic [7:0] s;

		// AES S-box from the multiplicative inverse in GF(2^8) plus the
		// affine map: p steps through powers of 3 and q through powers of 1/3
		p = 8'h01;
		q = 8'h01;
		do begin
			p = p ^ {p[6:0], 1'b0} ^ (p[7] ? 8'h1B : 8'h00);
			q = q ^ {q[6:0], 1'b0};
			q = q ^ {q[5:0], 2'b00};
			q = q ^ {q[3:0], 4'b0000};
			if (q[7])
				q = q ^ 8'h09;
			s = q ^ rotate_left8(q, 1) ^ rotate_left8(q, 2) ^ rotate_left8(q, 3)
				^ rotate_left8(q, 4) ^ 8'h63;
			fwd_sbox[p] = s;
			rev_sbox[s] = p;
		end while (p != 8'h01);
		fwd_sbox[8'h00] = 8'h63;
		rev_sbox[8'h63] = 8'h00;

		key_copy[REG_KEY_WORD0] = KEY_DEFAULT[31:0];
		key_copy[REG_KEY_WORD1] = KEY_DEFAULT[63:32];
		key_copy[REG_KEY_WORD2] = KEY_DEFAULT[95:64];
		key_copy[REG_KEY_WORD3] = KEY_DEFAULT[127:96];
		byte_index    = '0;
		rot_phase     = PHASE_START;
		run_mask      = '0;
		error_count   = 0;
		quiet_cycles  = 0;
		in_gap_max    = 0;
		out_stall_max = 0;

		arst_n                 <= 1'b0;
		din_if.valid           <= 1'b0;
		din_if.action          <= ACT_ENCRYPT;
		din_if.data_byte       <= '0;
		din_if.last_of_message <= 1'b0;
		cfg_if.valid           <= 1'b0;
		cfg_if.index           <= REG_KEY_WORD0;
		cfg_if.data            <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_extremes();
		test_key_midmessage();
		test_key_sweep();
		test_long_message();

		// Everything sent: wait for the last results, then keep watching dout
		// to catch any stray extra result
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_bytes.size() == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

FILE: keyed_sbox_rotate_byte_cipher.f
rtl/core/kbc_pkg.sv
rtl/core/kbc_if.sv
rtl/core/kbc_xform.sv
rtl/core/kbc_skid.sv
rtl/core/keyed_sbox_rotate_byte_cipher.sv
dv/tb.sv
